// ===== sv/ouk_pkg.sv =====
package ouk_pkg;

   localparam int KEY_BITS = 31;

   typedef enum logic [2:0] {
      REQ_INS_FRONT = 3'd0,
      REQ_INS_BACK  = 3'd1,
      REQ_REMOVE    = 3'd2,
      REQ_SEARCH    = 3'd3,
      REQ_COUNT     = 3'd4,
      REQ_DUMP      = 3'd5
   } req_code_type;

   typedef enum logic [2:0] {
      FAIL_NONE      = 3'd0,
      FAIL_NOT_POS   = 3'd1,
      FAIL_DUPLICATE = 3'd2,
      FAIL_FULL      = 3'd3,
      FAIL_NOT_FOUND = 3'd4
   } fail_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_SHIFT = 5'b00100,
      ST_DUMP  = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

endpackage

// ===== sv/ouk_req_if.sv =====
interface ouk_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         req_type;
   logic signed [31:0] key;

   modport source (output valid, output req_type, output key, input ready);
   modport sink (input valid, input req_type, input key, output ready);
endinterface

// ===== sv/ouk_rsp_if.sv =====
interface ouk_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [2:0]  fail_reason;
   logic [30:0] value;
   logic        last;

   modport source (output valid, output ok, output fail_reason, output value,
                   output last, input ready);
   modport sink (input valid, input ok, input fail_reason, input value,
                 input last, output ready);
endinterface

// ===== sv/ouk_mem.sv =====
module ouk_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 31
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ordered_unique_key_list_core.sv =====
// search, remove miss, insert back, duplicate: a scan of the entries, one entry read per cycle
// insert front and remove hit then shift the moved entries through the single read port, which sets the pace
// count, rejected key, empty dump: answered without a scan; dump: one result per cycle while the sink takes them
// one request at a time; the next is taken once the last result sits in the output register
// synchronous reset empties the list; entry storage is not cleared and needs no clearing pass
module ordered_unique_key_list_core #(
   parameter int CAPACITY = 16
) (
   input  logic      clock,
   input  logic      reset,
   ouk_req_if.sink   req_ch,
   ouk_rsp_if.source rsp_ch
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = ouk_pkg::KEY_BITS;
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_CNT = CW'(1);

   ouk_pkg::state_type state_ff, state_in;
   logic [2:0]         type_ff, type_in;
   logic [KW-1:0]      key_ff, key_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      rd_idx_ff, rd_idx_in;
   logic               pend_ff, pend_in;
   logic [CW-1:0]      pend_idx_ff, pend_idx_in;
   logic               res_ok_ff, res_ok_in;
   logic [2:0]         res_reason_ff, res_reason_in;
   logic [KW-1:0]      res_value_ff, res_value_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [2:0]         rsp_reason_ff, rsp_reason_in;
   logic [KW-1:0]      rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               mem_we, mem_re;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [KW-1:0]      mem_wdata, mem_rdata;

   logic               out_free, key_pos, hit, more, is_remove, dump_last;

   ouk_mem #(.DEPTH(CAPACITY), .AW(AW), .DW(KW)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign key_pos       = (req_ch.key != 32'sd0) && !req_ch.key[31];
   assign hit           = pend_ff && (mem_rdata == key_ff);
   assign is_remove     = (type_ff == ouk_pkg::REQ_REMOVE);
   assign dump_last     = ((pend_idx_ff + ONE_CNT) == count_ff);
   assign req_ch.ready  = (state_ff == ouk_pkg::ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      res_ok_in     = res_ok_ff;
      res_reason_in = res_reason_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_reason_in = rsp_reason_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = mem_rdata;
      mem_re        = 1'b0;
      mem_raddr     = rd_idx_ff[AW-1:0];
      more          = 1'b0;

      case (state_ff)
         ouk_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               type_in       = req_ch.req_type;
               key_in        = req_ch.key[KW-1:0];
               rd_idx_in     = '0;
               pend_in       = 1'b0;
               res_ok_in     = 1'b0;
               res_reason_in = ouk_pkg::FAIL_NONE;
               res_value_in  = '0;
               case (req_ch.req_type)
                  ouk_pkg::REQ_INS_FRONT, ouk_pkg::REQ_INS_BACK,
                  ouk_pkg::REQ_REMOVE, ouk_pkg::REQ_SEARCH: begin
                     if (!key_pos) begin
                        res_reason_in = ouk_pkg::FAIL_NOT_POS;
                        state_in      = ouk_pkg::ST_RESP;
                     end else begin
                        state_in = ouk_pkg::ST_SCAN;
                     end
                  end
                  ouk_pkg::REQ_COUNT: begin
                     res_value_in = KW'(count_ff);
                     state_in     = ouk_pkg::ST_RESP;
                  end
                  ouk_pkg::REQ_DUMP: begin
                     if (count_ff == '0) begin
                        res_reason_in = ouk_pkg::FAIL_NOT_FOUND;
                        state_in      = ouk_pkg::ST_RESP;
                     end else begin
                        state_in = ouk_pkg::ST_DUMP;
                     end
                  end
                  default: begin
                     state_in = ouk_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         ouk_pkg::ST_SCAN: begin
            if (hit) begin
               case (type_ff)
                  ouk_pkg::REQ_INS_FRONT, ouk_pkg::REQ_INS_BACK: begin
                     res_reason_in = ouk_pkg::FAIL_DUPLICATE;
                     state_in      = ouk_pkg::ST_RESP;
                  end
                  ouk_pkg::REQ_REMOVE: begin
                     rd_idx_in = pend_idx_ff + ONE_CNT;
                     pend_in   = 1'b0;
                     state_in  = ouk_pkg::ST_SHIFT;
                  end
                  default: begin
                     res_ok_in = 1'b1;
                     state_in  = ouk_pkg::ST_RESP;
                  end
               endcase
            end else if (rd_idx_ff < count_ff) begin
               mem_re      = 1'b1;
               mem_raddr   = rd_idx_ff[AW-1:0];
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff;
               rd_idx_in   = rd_idx_ff + ONE_CNT;
            end else begin
               pend_in = 1'b0;
               case (type_ff)
                  ouk_pkg::REQ_INS_FRONT, ouk_pkg::REQ_INS_BACK: begin
                     if (count_ff == CAP_CNT) begin
                        res_reason_in = ouk_pkg::FAIL_FULL;
                        state_in      = ouk_pkg::ST_RESP;
                     end else if (type_ff == ouk_pkg::REQ_INS_BACK) begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = key_ff;
                        count_in  = count_ff + ONE_CNT;
                        res_ok_in = 1'b1;
                        state_in  = ouk_pkg::ST_RESP;
                     end else begin
                        rd_idx_in = count_ff;
                        state_in  = ouk_pkg::ST_SHIFT;
                     end
                  end
                  default: begin
                     res_reason_in = ouk_pkg::FAIL_NOT_FOUND;
                     state_in      = ouk_pkg::ST_RESP;
                  end
               endcase
            end
         end

         ouk_pkg::ST_SHIFT: begin
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata;
               if (is_remove) begin
                  mem_waddr = AW'(pend_idx_ff - ONE_CNT);
               end else begin
                  mem_waddr = AW'(pend_idx_ff + ONE_CNT);
               end
            end
            if (is_remove) begin
               more = (rd_idx_ff < count_ff);
               if (more) begin
                  mem_re      = 1'b1;
                  mem_raddr   = rd_idx_ff[AW-1:0];
                  pend_idx_in = rd_idx_ff;
                  rd_idx_in   = rd_idx_ff + ONE_CNT;
               end
            end else begin
               more = (rd_idx_ff != '0);
               if (more) begin
                  mem_re      = 1'b1;
                  mem_raddr   = AW'(rd_idx_ff - ONE_CNT);
                  pend_idx_in = rd_idx_ff - ONE_CNT;
                  rd_idx_in   = rd_idx_ff - ONE_CNT;
               end
            end
            pend_in = more;
            if (!more && !pend_ff) begin
               if (is_remove) begin
                  count_in = count_ff - ONE_CNT;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = key_ff;
                  count_in  = count_ff + ONE_CNT;
               end
               res_ok_in = 1'b1;
               state_in  = ouk_pkg::ST_RESP;
            end
         end

         ouk_pkg::ST_DUMP: begin
            if (!pend_ff) begin
               mem_re      = 1'b1;
               mem_raddr   = rd_idx_ff[AW-1:0];
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff;
               rd_idx_in   = rd_idx_ff + ONE_CNT;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = 1'b1;
               rsp_reason_in = ouk_pkg::FAIL_NONE;
               rsp_value_in  = mem_rdata;
               rsp_last_in   = dump_last;
               if (dump_last) begin
                  pend_in  = 1'b0;
                  state_in = ouk_pkg::ST_IDLE;
               end else begin
                  mem_re      = 1'b1;
                  mem_raddr   = rd_idx_ff[AW-1:0];
                  pend_idx_in = rd_idx_ff;
                  rd_idx_in   = rd_idx_ff + ONE_CNT;
               end
            end
         end

         ouk_pkg::ST_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = res_ok_ff;
               rsp_reason_in = res_reason_ff;
               rsp_value_in  = res_value_ff;
               rsp_last_in   = 1'b1;
               state_in      = ouk_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ouk_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ouk_pkg::ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff       <= type_in;
      key_ff        <= key_in;
      rd_idx_ff     <= rd_idx_in;
      pend_idx_ff   <= pend_idx_in;
      res_ok_ff     <= res_ok_in;
      res_reason_ff <= res_reason_in;
      res_value_ff  <= res_value_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_reason_ff <= rsp_reason_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.ok          = rsp_ok_ff;
   assign rsp_ch.fail_reason = rsp_reason_ff;
   assign rsp_ch.value       = rsp_value_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // list never grows past capacity
   assert property (@(posedge clock) disable iff (reset) count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   // entry count moves by at most one per request
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ((count_ff == $past(count_ff) + ONE_CNT) || (count_ff + ONE_CNT == $past(count_ff))))
      else $error("entry count jumped");

   // writes stay inside the table
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_waddr) < CAPACITY))
      else $error("entry write out of range");

   // dump runs only over a non-empty list
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ouk_pkg::ST_DUMP) |-> (count_ff != '0))
      else $error("dump with empty list");

endmodule

// ===== test/tb.sv =====
typedef struct packed {
   logic              ok;
   ouk_pkg::fail_type reason;
   logic [30:0]       value;
   logic              last;
} list_rsp_type;

class key_list_board;
   int           capacity;
   bit [30:0]    keys[$];
   list_rsp_type pending[$];
   int           errors;
   int           requests;
   int           spare_codes;
   int           results_seen;
   int           longest_dump;
   int           reason_tally[8];

   function new(int cap);
      capacity = cap;
   endfunction

   function void add_rsp(bit ok, ouk_pkg::fail_type reason, bit [30:0] value, bit last);
      list_rsp_type r;
      r.ok = ok;
      r.reason = reason;
      r.value = value;
      r.last = last;
      pending.push_back(r);
      reason_tally[int'(reason)]++;
   endfunction

   function int find_key(bit [30:0] k);
      foreach (keys[i]) begin
         if (keys[i] == k) return i;
      end
      return -1;
   endfunction

   // work out the results of one accepted request and update the list copy
   function void note_request(logic [2:0] code, logic [31:0] key);
      bit        positive;
      bit [30:0] k;
      int        pos;
      positive = (key != 32'd0) && !key[31];
      k = key[30:0];
      pos = find_key(k);
      requests++;
      case (code)
         ouk_pkg::REQ_INS_FRONT, ouk_pkg::REQ_INS_BACK: begin
            if (!positive) add_rsp(1'b0, ouk_pkg::FAIL_NOT_POS, '0, 1'b1);
            else if (pos >= 0) add_rsp(1'b0, ouk_pkg::FAIL_DUPLICATE, '0, 1'b1);
            else if (keys.size() >= capacity) add_rsp(1'b0, ouk_pkg::FAIL_FULL, '0, 1'b1);
            else begin
               if (code == ouk_pkg::REQ_INS_FRONT) keys.push_front(k);
               else keys.push_back(k);
               add_rsp(1'b1, ouk_pkg::FAIL_NONE, '0, 1'b1);
            end
         end
         ouk_pkg::REQ_REMOVE: begin
            if (!positive) add_rsp(1'b0, ouk_pkg::FAIL_NOT_POS, '0, 1'b1);
            else if (pos < 0) add_rsp(1'b0, ouk_pkg::FAIL_NOT_FOUND, '0, 1'b1);
            else begin
               keys.delete(pos);
               add_rsp(1'b1, ouk_pkg::FAIL_NONE, '0, 1'b1);
            end
         end
         ouk_pkg::REQ_SEARCH: begin
            if (!positive) add_rsp(1'b0, ouk_pkg::FAIL_NOT_POS, '0, 1'b1);
            else if (pos >= 0) add_rsp(1'b1, ouk_pkg::FAIL_NONE, '0, 1'b1);
            else add_rsp(1'b0, ouk_pkg::FAIL_NOT_FOUND, '0, 1'b1);
         end
         ouk_pkg::REQ_COUNT: add_rsp(1'b0, ouk_pkg::FAIL_NONE, 31'(keys.size()), 1'b1);
         ouk_pkg::REQ_DUMP: begin
            if (keys.size() == 0) add_rsp(1'b0, ouk_pkg::FAIL_NOT_FOUND, '0, 1'b1);
            else begin
               foreach (keys[i])
                  add_rsp(1'b1, ouk_pkg::FAIL_NONE, keys[i], i == keys.size() - 1);
               if (keys.size() > longest_dump) longest_dump = keys.size();
            end
         end
         default: spare_codes++;
      endcase
   endfunction

   function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("tb: mismatch: %s", msg);
   endfunction

   function void check_rsp(logic ok, logic [2:0] reason, logic [30:0] value, logic last);
      list_rsp_type e;
      results_seen++;
      if (pending.size() == 0) begin
         note_error($sformatf("result with nothing outstanding: ok=%0b reason=%0d value=%0d last=%0b",
                              ok, reason, value, last));
         return;
      end
      e = pending.pop_front();
      if (ok !== e.ok || reason !== e.reason || value !== e.value || last !== e.last)
         note_error($sformatf({"result %0d: expected ok=%0b reason=%0d value=%0d last=%0b,",
                               " got ok=%0b reason=%0d value=%0d last=%0b"},
                              results_seen, e.ok, e.reason, e.value, e.last,
                              ok, reason, value, last));
   endfunction
endclass

module tb;

   localparam int CAPACITY = 16;
   localparam int ITEMS = 120;
   localparam int QUIET_LIMIT = 1000;
   localparam int TAIL_CYCLES = 80;
   localparam logic [2:0] REQ_SPARE_LO = 3'd6;
   localparam logic [2:0] REQ_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset;
   bit   calm = 1'b0;
   int   stall_left = 0;
   int   quiet_cycles = 0;

   key_list_board board = new(CAPACITY);

   ouk_req_if req_ch();
   ouk_rsp_if rsp_ch();

   ordered_unique_key_list_core #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 8);
      return $urandom_range(15, 30);
   endfunction

   function automatic logic [2:0] pick_code();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25) return ouk_pkg::REQ_INS_FRONT;
      if (r < 45) return ouk_pkg::REQ_INS_BACK;
      if (r < 62) return ouk_pkg::REQ_REMOVE;
      if (r < 77) return ouk_pkg::REQ_SEARCH;
      if (r < 85) return ouk_pkg::REQ_COUNT;
      if (r < 96) return ouk_pkg::REQ_DUMP;
      return $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
   endfunction

   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45 && board.keys.size() > 0)
         return {1'b0, board.keys[$urandom_range(0, board.keys.size() - 1)]};
      if (r < 70) return $urandom_range(1, 24);
      if (r < 80) return $urandom;
      if (r < 88) return $urandom_range(1, 32'h7fff_ffff);
      case ($urandom_range(0, 3))
         0: return 32'h0000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h8000_0000;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   task automatic send_request(logic [2:0] code, logic [31:0] key);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= code;
      req_ch.key <= key;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(code, key);
   endtask

   // result sink with random stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         board.check_rsp(rsp_ch.ok, rsp_ch.fail_reason, rsp_ch.value, rsp_ch.last);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: no transfer for %0d cycles", QUIET_LIMIT);
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      logic [2:0] code;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.req_type = ouk_pkg::REQ_INS_FRONT;
      req_ch.key = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty list, rejected keys, unused codes, edges of the key range
      send_request(ouk_pkg::REQ_DUMP, 32'd0);
      send_request(ouk_pkg::REQ_COUNT, 32'd0);
      send_request(ouk_pkg::REQ_SEARCH, 32'd5);
      send_request(ouk_pkg::REQ_REMOVE, 32'd5);
      send_request(ouk_pkg::REQ_INS_FRONT, 32'd0);
      send_request(ouk_pkg::REQ_INS_BACK, 32'hffff_ffff);
      send_request(ouk_pkg::REQ_REMOVE, 32'h8000_0000);
      send_request(ouk_pkg::REQ_SEARCH, 32'hffff_fffb);
      send_request(REQ_SPARE_LO, 32'd3);
      send_request(REQ_SPARE_HI, 32'hffff_ffff);
      send_request(ouk_pkg::REQ_INS_BACK, 32'h7fff_ffff);
      send_request(ouk_pkg::REQ_INS_FRONT, 32'd1);
      send_request(ouk_pkg::REQ_INS_FRONT, 32'd1);
      send_request(ouk_pkg::REQ_INS_BACK, 32'h5555_5555);
      send_request(ouk_pkg::REQ_SEARCH, 32'h7fff_ffff);
      send_request(ouk_pkg::REQ_SEARCH, 32'd2);
      send_request(ouk_pkg::REQ_COUNT, 32'd0);
      send_request(ouk_pkg::REQ_DUMP, 32'd0);
      send_request(ouk_pkg::REQ_REMOVE, 32'h5555_5555);
      send_request(ouk_pkg::REQ_REMOVE, 32'd1);
      send_request(ouk_pkg::REQ_REMOVE, 32'd1);
      send_request(ouk_pkg::REQ_DUMP, 32'd0);
      send_request(ouk_pkg::REQ_COUNT, 32'd0);

      // fill to capacity, then duplicate, full and non-positive on a full list
      while (board.keys.size() < CAPACITY) begin
         send_request($urandom_range(0, 1) ? ouk_pkg::REQ_INS_BACK : ouk_pkg::REQ_INS_FRONT,
                      $urandom_range(1, 1000));
      end
      send_request(ouk_pkg::REQ_INS_FRONT, {1'b0, board.keys[CAPACITY / 2]});
      send_request(ouk_pkg::REQ_INS_BACK, 32'd1001);
      send_request(ouk_pkg::REQ_INS_FRONT, 32'd0);
      send_request(ouk_pkg::REQ_DUMP, 32'd0);
      send_request(ouk_pkg::REQ_COUNT, 32'd0);

      while (board.requests < ITEMS) begin
         if (board.requests % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         code = pick_code();
         send_request(code, pick_key());
      end
      req_ch.valid <= 1'b0;
      calm = 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tb: %0d requests (%0d with unused codes), %0d results, longest dump %0d",
               board.requests, board.spare_codes, board.results_seen, board.longest_dump);
      $display("tb: rejections: %0d not positive, %0d duplicate, %0d full, %0d not found",
               board.reason_tally[ouk_pkg::FAIL_NOT_POS],
               board.reason_tally[ouk_pkg::FAIL_DUPLICATE],
               board.reason_tally[ouk_pkg::FAIL_FULL],
               board.reason_tally[ouk_pkg::FAIL_NOT_FOUND]);
      if (board.errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: %0d mismatches", board.errors);
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
